FILE: design/dhcp_rop_pkg.sv
// ----------------------------------------------------------------------------
// dhcp_rop_pkg
// shared types and constants of the dhcp reply option parser
// ----------------------------------------------------------------------------
package dhcp_rop_pkg;

  localparam int unsigned HeaderBytes     = 240;
  localparam int unsigned MaxPayloadBytes = 2047;

  // fixed header offsets
  localparam int unsigned OFF_OPCODE    = 0;
  localparam int unsigned OFF_XID_FIRST = 4;
  localparam int unsigned OFF_XID_LAST  = 7;
  localparam int unsigned OFF_YI_FIRST  = 16;
  localparam int unsigned OFF_YI_LAST   = 19;
  localparam int unsigned OFF_SI_FIRST  = 20;
  localparam int unsigned OFF_SI_LAST   = 23;

  localparam logic [7:0] OP_REPLY = 8'd2;

  // option codes
  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_MASK      = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_DNS       = 8'd6;
  localparam logic [7:0] OPT_DOMAIN    = 8'd15;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_TYPE      = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;
  localparam logic [7:0] OPT_END       = 8'd255;

  // present mask bits
  localparam int unsigned FLAG_TYPE   = 0;
  localparam int unsigned FLAG_MASK   = 1;
  localparam int unsigned FLAG_ROUTER = 2;
  localparam int unsigned FLAG_SERVER = 3;
  localparam int unsigned FLAG_DNS1   = 4;
  localparam int unsigned FLAG_DNS2   = 5;
  localparam int unsigned FLAG_LEASE  = 6;
  localparam int unsigned FLAG_DOMAIN = 7;

  // parse status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_CUT   = 2'd2;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_CODE   = 4'b0010,
    PH_LEN    = 4'b0100,
    PH_VALUE  = 4'b1000
  } dhcp_rop_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dhcp_rop_in_t;

  typedef struct packed {
    logic        reply_ok;
    logic [7:0]  message_type;
    logic [31:0] your_addr;
    logic [31:0] server_addr;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
    logic [31:0] lease_seconds;
    logic [7:0]  present_mask;
    logic [1:0]  parse_status;
  } dhcp_rop_out_t;

endpackage

FILE: design/dhcp_rop_core.sv
// ----------------------------------------------------------------------------
// dhcp_rop_core
// per-byte header capture and option walk, builds the result of a payload
// ----------------------------------------------------------------------------
module dhcp_rop_core #(
  parameter int unsigned MaxPayloadBytes = dhcp_rop_pkg::MaxPayloadBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  dhcp_rop_pkg::dhcp_rop_in_t   item_i,
  input  logic [31:0]                  expected_xid_i,
  output dhcp_rop_pkg::dhcp_rop_out_t  result_o
);

  localparam int unsigned OffW = $clog2(MaxPayloadBytes + 1);
  localparam logic [OffW-1:0] OffMax = OffW'(MaxPayloadBytes);

  logic [OffW-1:0]               offset_q, offset_d;
  dhcp_rop_pkg::dhcp_rop_phase_e phase_q, phase_d;
  logic [7:0]                    code_q, code_d;
  logic [7:0]                    remaining_q, remaining_d;
  logic [2:0]                    index_q, index_d;
  logic [31:0]                   shift_q, shift_d;
  logic [31:0]                   xid_q, xid_d;
  logic [7:0]                    opcode_q, opcode_d;
  logic [7:0]                    type_q, type_d;
  logic [31:0]                   yiaddr_q, yiaddr_d;
  logic [31:0]                   server_q, server_d;
  logic [31:0]                   mask_q, mask_d;
  logic [31:0]                   router_q, router_d;
  logic [31:0]                   dns1_q, dns1_d;
  logic [31:0]                   dns2_q, dns2_d;
  logic [31:0]                   lease_q, lease_d;
  logic [7:0]                    flags_q, flags_d;
  logic                          keep;
  logic [7:0]                    b;
  logic [31:0]                   shift_new;
  logic [1:0]                    status;

  assign b         = item_i.data_byte;
  assign shift_new = {shift_q[23:0], b};

  always_comb begin
    offset_d    = offset_q;
    phase_d     = phase_q;
    code_d      = code_q;
    remaining_d = remaining_q;
    index_d     = index_q;
    shift_d     = shift_q;
    xid_d       = xid_q;
    opcode_d    = opcode_q;
    type_d      = type_q;
    yiaddr_d    = yiaddr_q;
    server_d    = server_q;
    mask_d      = mask_q;
    router_d    = router_q;
    dns1_d      = dns1_q;
    dns2_d      = dns2_q;
    lease_d     = lease_q;
    flags_d     = flags_q;
    keep        = 1'b0;
    if (offset_q < OffMax) begin
      offset_d = offset_q + 1'b1;
      unique case (phase_q)
        dhcp_rop_pkg::PH_HEADER: begin
          if (offset_q == OffW'(dhcp_rop_pkg::OFF_OPCODE)) begin
            opcode_d = b;
          end
          if (offset_q >= OffW'(dhcp_rop_pkg::OFF_XID_FIRST) &&
              offset_q <= OffW'(dhcp_rop_pkg::OFF_XID_LAST)) begin
            xid_d = {xid_q[23:0], b};
          end
          if (offset_q >= OffW'(dhcp_rop_pkg::OFF_YI_FIRST) &&
              offset_q <= OffW'(dhcp_rop_pkg::OFF_YI_LAST)) begin
            yiaddr_d = {yiaddr_q[23:0], b};
          end
          if (offset_q >= OffW'(dhcp_rop_pkg::OFF_SI_FIRST) &&
              offset_q <= OffW'(dhcp_rop_pkg::OFF_SI_LAST)) begin
            server_d = {server_q[23:0], b};
          end
          if (offset_q >= OffW'(dhcp_rop_pkg::HeaderBytes - 1)) begin
            phase_d = dhcp_rop_pkg::PH_CODE;
          end
        end
        dhcp_rop_pkg::PH_CODE: begin
          priority if (b == dhcp_rop_pkg::OPT_END) begin
            code_d  = dhcp_rop_pkg::OPT_END;
            phase_d = dhcp_rop_pkg::PH_VALUE;
          end else if (b != dhcp_rop_pkg::OPT_PAD) begin
            code_d  = b;
            phase_d = dhcp_rop_pkg::PH_LEN;
          end else begin
            code_d = code_q;
          end
        end
        dhcp_rop_pkg::PH_LEN: begin
          remaining_d = b;
          index_d     = '0;
          shift_d     = '0;
          unique case (code_q)
            dhcp_rop_pkg::OPT_TYPE:
              keep = (b >= 8'd1) && !flags_q[dhcp_rop_pkg::FLAG_TYPE];
            dhcp_rop_pkg::OPT_MASK:
              keep = (b >= 8'd4) && !flags_q[dhcp_rop_pkg::FLAG_MASK];
            dhcp_rop_pkg::OPT_ROUTER:
              keep = (b >= 8'd4) && !flags_q[dhcp_rop_pkg::FLAG_ROUTER];
            dhcp_rop_pkg::OPT_SERVER_ID:
              keep = (b >= 8'd4) && !flags_q[dhcp_rop_pkg::FLAG_SERVER];
            dhcp_rop_pkg::OPT_DNS:
              keep = (b >= 8'd4) && !flags_q[dhcp_rop_pkg::FLAG_DNS1];
            dhcp_rop_pkg::OPT_LEASE:
              keep = (b >= 8'd4) && !flags_q[dhcp_rop_pkg::FLAG_LEASE];
            dhcp_rop_pkg::OPT_DOMAIN:
              flags_d[dhcp_rop_pkg::FLAG_DOMAIN] = 1'b1;
            default: keep = 1'b0;
          endcase
          if (!keep) begin
            code_d = dhcp_rop_pkg::OPT_PAD;
          end
          phase_d = (b == 8'd0) ? dhcp_rop_pkg::PH_CODE : dhcp_rop_pkg::PH_VALUE;
        end
        dhcp_rop_pkg::PH_VALUE: begin
          if (code_q != dhcp_rop_pkg::OPT_END) begin
            shift_d = shift_new;
            priority if (index_q == 3'd0 && code_q == dhcp_rop_pkg::OPT_TYPE) begin
              type_d = b;
              flags_d[dhcp_rop_pkg::FLAG_TYPE] = 1'b1;
            end else if (index_q == 3'd3) begin
              unique case (code_q)
                dhcp_rop_pkg::OPT_MASK: begin
                  mask_d = shift_new;
                  flags_d[dhcp_rop_pkg::FLAG_MASK] = 1'b1;
                end
                dhcp_rop_pkg::OPT_ROUTER: begin
                  router_d = shift_new;
                  flags_d[dhcp_rop_pkg::FLAG_ROUTER] = 1'b1;
                end
                dhcp_rop_pkg::OPT_SERVER_ID: begin
                  server_d = shift_new;
                  flags_d[dhcp_rop_pkg::FLAG_SERVER] = 1'b1;
                end
                dhcp_rop_pkg::OPT_DNS: begin
                  dns1_d = shift_new;
                  flags_d[dhcp_rop_pkg::FLAG_DNS1] = 1'b1;
                end
                dhcp_rop_pkg::OPT_LEASE: begin
                  lease_d = shift_new;
                  flags_d[dhcp_rop_pkg::FLAG_LEASE] = 1'b1;
                end
                default: ;
              endcase
            end else if (index_q == 3'd7 && code_q == dhcp_rop_pkg::OPT_DNS &&
                         !flags_q[dhcp_rop_pkg::FLAG_DNS2]) begin
              dns2_d = shift_new;
              flags_d[dhcp_rop_pkg::FLAG_DNS2] = 1'b1;
            end else begin
              shift_d = shift_new;
            end
            if (index_q != 3'd7) begin
              index_d = index_q + 3'd1;
            end
            remaining_d = remaining_q - 8'd1;
            if (remaining_q == 8'd1) begin
              phase_d = dhcp_rop_pkg::PH_CODE;
            end
          end
        end
        default: phase_d = dhcp_rop_pkg::PH_HEADER;
      endcase
    end
  end

  always_comb begin
    priority if (phase_d == dhcp_rop_pkg::PH_HEADER) begin
      status = dhcp_rop_pkg::STATUS_SHORT;
    end else if (phase_d == dhcp_rop_pkg::PH_LEN ||
                 (phase_d == dhcp_rop_pkg::PH_VALUE && code_d != dhcp_rop_pkg::OPT_END)) begin
      status = dhcp_rop_pkg::STATUS_CUT;
    end else begin
      status = dhcp_rop_pkg::STATUS_OK;
    end
  end

  always_comb begin
    result_o = '0;
    result_o.parse_status = status;
    if (status != dhcp_rop_pkg::STATUS_SHORT) begin
      result_o.reply_ok      = (opcode_d == dhcp_rop_pkg::OP_REPLY) &&
                               (xid_d == expected_xid_i);
      result_o.message_type  = type_d;
      result_o.your_addr     = yiaddr_d;
      result_o.server_addr   = server_d;
      result_o.subnet_mask   = mask_d;
      result_o.router_addr   = router_d;
      result_o.dns_primary   = dns1_d;
      result_o.dns_secondary = dns2_d;
      result_o.lease_seconds = lease_d;
      result_o.present_mask  = flags_d;
    end
  end

  // last byte clears all packet state for the next payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      phase_q     <= dhcp_rop_pkg::PH_HEADER;
      code_q      <= '0;
      remaining_q <= '0;
      index_q     <= '0;
      shift_q     <= '0;
      xid_q       <= '0;
      opcode_q    <= '0;
      type_q      <= '0;
      yiaddr_q    <= '0;
      server_q    <= '0;
      mask_q      <= '0;
      router_q    <= '0;
      dns1_q      <= '0;
      dns2_q      <= '0;
      lease_q     <= '0;
      flags_q     <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        offset_q    <= '0;
        phase_q     <= dhcp_rop_pkg::PH_HEADER;
        code_q      <= '0;
        remaining_q <= '0;
        index_q     <= '0;
        shift_q     <= '0;
        xid_q       <= '0;
        opcode_q    <= '0;
        type_q      <= '0;
        yiaddr_q    <= '0;
        server_q    <= '0;
        mask_q      <= '0;
        router_q    <= '0;
        dns1_q      <= '0;
        dns2_q      <= '0;
        lease_q     <= '0;
        flags_q     <= '0;
      end else begin
        offset_q    <= offset_d;
        phase_q     <= phase_d;
        code_q      <= code_d;
        remaining_q <= remaining_d;
        index_q     <= index_d;
        shift_q     <= shift_d;
        xid_q       <= xid_d;
        opcode_q    <= opcode_d;
        type_q      <= type_d;
        yiaddr_q    <= yiaddr_d;
        server_q    <= server_d;
        mask_q      <= mask_d;
        router_q    <= router_d;
        dns1_q      <= dns1_d;
        dns2_q      <= dns2_d;
        lease_q     <= lease_d;
        flags_q     <= flags_d;
      end
    end
  end

endmodule

FILE: design/dhcp_reply_option_parser.sv
// ----------------------------------------------------------------------------
// dhcp_reply_option_parser
// result: the last byte passes the input register, then the result is registered in out_q
// throughput: one byte per cycle, but the last byte of a payload waits while a result is held
// reset: parse state, transaction id register and both valid flags clear
// walks a dhcp reply byte stream and reports header and option fields
// ----------------------------------------------------------------------------
module dhcp_reply_option_parser #(
  parameter int unsigned MaxPayloadBytes = dhcp_rop_pkg::MaxPayloadBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dhcp_rop_pkg::dhcp_rop_in_t  in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dhcp_rop_pkg::dhcp_rop_out_t out_data_o,
  input  logic                        cfg_we_i,
  input  logic [31:0]                 cfg_wdata_i
);

  logic                        in_valid_q;
  dhcp_rop_pkg::dhcp_rop_in_t  in_q;
  logic                        out_valid_q;
  dhcp_rop_pkg::dhcp_rop_out_t out_q;
  logic [31:0]                 xid_q;
  logic                        advance;
  dhcp_rop_pkg::dhcp_rop_out_t result;

  // a byte that makes no result never waits for the output side
  assign advance    = in_valid_q && (!in_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q <= '0;
    end else if (cfg_we_i) begin
      xid_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  dhcp_rop_core #(
    .MaxPayloadBytes(MaxPayloadBytes)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .expected_xid_i(xid_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last_byte) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_short_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parse_status == dhcp_rop_pkg::STATUS_SHORT |->
      !out_data_o.reply_ok && out_data_o.present_mask == 8'd0)
    else $error("short header result carries fields");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.parse_status == dhcp_rop_pkg::STATUS_OK ||
                     out_data_o.parse_status == dhcp_rop_pkg::STATUS_SHORT ||
                     out_data_o.parse_status == dhcp_rop_pkg::STATUS_CUT))
    else $error("undefined parse status");

  a_dns_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.present_mask[dhcp_rop_pkg::FLAG_DNS2] |->
      out_data_o.present_mask[dhcp_rop_pkg::FLAG_DNS1])
    else $error("secondary dns without primary");

  a_held_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held input byte lost");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dhcp reply option parser: directed payloads
// cover duplicate, short, pad, end and unknown options and a cut-off value,
// then short payloads run under several sender and receiver idling mixes
// while a local predictor checks every reported result
// ----------------------------------------------------------------------------
import dhcp_rop_pkg::*;

class dhcp_reply_checker;
  logic [31:0]     xid_cfg;
  logic [10:0]     offset;
  dhcp_rop_phase_e phase;
  logic [7:0]      code;
  logic [7:0]      remaining;
  logic [2:0]      vidx;
  logic [31:0]     shifter;
  logic [31:0]     xid_hdr;
  logic [7:0]      opcode;
  logic [7:0]      msg_type;
  logic [31:0]     yiaddr, srv, mask, router, dns1, dns2, lease;
  logic [7:0]      flags;
  dhcp_rop_out_t   expected_replies[$];
  int              mismatches;
  int              status_count[3];
  int              valid_replies;

  function new();
    xid_cfg = '0;
    mismatches = 0;
    valid_replies = 0;
    status_count = '{0, 0, 0};
    clear_packet();
  endfunction

  function void clear_packet();
    offset = '0;
    phase = PH_HEADER;
    code = '0;
    remaining = '0;
    vidx = '0;
    shifter = '0;
    xid_hdr = '0;
    opcode = '0;
    msg_type = '0;
    yiaddr = '0;
    srv = '0;
    mask = '0;
    router = '0;
    dns1 = '0;
    dns2 = '0;
    lease = '0;
    flags = '0;
  endfunction

  function void take_header(logic [7:0] b);
    if (offset == OFF_OPCODE) begin
      opcode = b;
    end else if (offset >= OFF_XID_FIRST && offset <= OFF_XID_LAST) begin
      xid_hdr = {xid_hdr[23:0], b};
    end else if (offset >= OFF_YI_FIRST && offset <= OFF_YI_LAST) begin
      yiaddr = {yiaddr[23:0], b};
    end else if (offset >= OFF_SI_FIRST && offset <= OFF_SI_LAST) begin
      srv = {srv[23:0], b};
    end
    if (int'(offset) + 1 >= HeaderBytes) phase = PH_CODE;
  endfunction

  function void take_length(logic [7:0] b);
    logic keep;
    keep = 1'b0;
    remaining = b;
    vidx = '0;
    shifter = '0;
    case (code)
      OPT_TYPE:      keep = b >= 1 && !flags[FLAG_TYPE];
      OPT_MASK:      keep = b >= 4 && !flags[FLAG_MASK];
      OPT_ROUTER:    keep = b >= 4 && !flags[FLAG_ROUTER];
      OPT_SERVER_ID: keep = b >= 4 && !flags[FLAG_SERVER];
      OPT_DNS:       keep = b >= 4 && !flags[FLAG_DNS1];
      OPT_LEASE:     keep = b >= 4 && !flags[FLAG_LEASE];
      OPT_DOMAIN:    flags[FLAG_DOMAIN] = 1'b1;
      default: ;
    endcase
    // a dropped option walks its value with the pad code
    if (!keep) code = OPT_PAD;
    phase = (b == 0) ? PH_CODE : PH_VALUE;
  endfunction

  function void take_value(logic [7:0] b);
    if (code == OPT_END) return;
    shifter = {shifter[23:0], b};
    if (vidx == 0 && code == OPT_TYPE) begin
      msg_type = b;
      flags[FLAG_TYPE] = 1'b1;
    end else if (vidx == 3) begin
      case (code)
        OPT_MASK: begin
          mask = shifter;
          flags[FLAG_MASK] = 1'b1;
        end
        OPT_ROUTER: begin
          router = shifter;
          flags[FLAG_ROUTER] = 1'b1;
        end
        OPT_SERVER_ID: begin
          srv = shifter;
          flags[FLAG_SERVER] = 1'b1;
        end
        OPT_DNS: begin
          dns1 = shifter;
          flags[FLAG_DNS1] = 1'b1;
        end
        OPT_LEASE: begin
          lease = shifter;
          flags[FLAG_LEASE] = 1'b1;
        end
        default: ;
      endcase
    end else if (vidx == 7 && code == OPT_DNS && !flags[FLAG_DNS2]) begin
      dns2 = shifter;
      flags[FLAG_DNS2] = 1'b1;
    end
    if (vidx < 7) vidx++;
    remaining = remaining - 8'd1;
    if (remaining == 0) phase = PH_CODE;
  endfunction

  function void take_byte(dhcp_rop_in_t t);
    dhcp_rop_out_t r;
    logic [1:0]    st;
    if (offset < MaxPayloadBytes) begin
      case (phase)
        PH_HEADER: take_header(t.data_byte);
        PH_CODE: begin
          if (t.data_byte == OPT_END) begin
            code = OPT_END;
            phase = PH_VALUE;
          end else if (t.data_byte != OPT_PAD) begin
            code = t.data_byte;
            phase = PH_LEN;
          end
        end
        PH_LEN: take_length(t.data_byte);
        default: take_value(t.data_byte);
      endcase
      offset++;
    end
    if (!t.last_byte) return;
    if (phase == PH_HEADER) begin
      st = STATUS_SHORT;
    end else if (phase == PH_LEN || (phase == PH_VALUE && code != OPT_END)) begin
      st = STATUS_CUT;
    end else begin
      st = STATUS_OK;
    end
    r = '0;
    if (st != STATUS_SHORT) begin
      r.reply_ok      = opcode == OP_REPLY && xid_hdr == xid_cfg;
      r.message_type  = msg_type;
      r.your_addr     = yiaddr;
      r.server_addr   = srv;
      r.subnet_mask   = mask;
      r.router_addr   = router;
      r.dns_primary   = dns1;
      r.dns_secondary = dns2;
      r.lease_seconds = lease;
      r.present_mask  = flags;
    end
    r.parse_status = st;
    expected_replies.push_back(r);
    clear_packet();
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function void diff(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) report($sformatf("%s expected %h got %h", name, e, g));
  endfunction

  function void check_reply(dhcp_rop_out_t got);
    dhcp_rop_out_t e;
    if (expected_replies.size() == 0) begin
      report($sformatf("result with nothing pending: %h", got));
      return;
    end
    e = expected_replies.pop_front();
    diff("reply_ok", e.reply_ok, got.reply_ok);
    diff("message_type", e.message_type, got.message_type);
    diff("your_addr", e.your_addr, got.your_addr);
    diff("server_addr", e.server_addr, got.server_addr);
    diff("subnet_mask", e.subnet_mask, got.subnet_mask);
    diff("router_addr", e.router_addr, got.router_addr);
    diff("dns_primary", e.dns_primary, got.dns_primary);
    diff("dns_secondary", e.dns_secondary, got.dns_secondary);
    diff("lease_seconds", e.lease_seconds, got.lease_seconds);
    diff("present_mask", e.present_mask, got.present_mask);
    diff("parse_status", e.parse_status, got.parse_status);
    if (e.parse_status <= STATUS_CUT) status_count[e.parse_status]++;
    if (e.reply_ok) valid_replies++;
  endfunction
endclass

module tb_top;
  localparam int          CycleLimit    = 800000;
  localparam int          DrainCycles   = 8;
  localparam int          HoldCycles    = 300;
  localparam int          ShortPerPhase = 6;
  localparam int          HoldPayloads  = 12;
  localparam logic [7:0]  OP_REQUEST    = 8'd1;
  localparam logic [7:0]  OPT_PRIVATE   = 8'd224;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  dhcp_rop_in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  dhcp_rop_out_t out_data_o;
  logic          cfg_we_i = 1'b0;
  logic [31:0]   cfg_wdata_i = '0;

  dhcp_reply_checker chk = new();
  logic [7:0]        pkt_bytes[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  logic              hold_active = 1'b0;
  event              start_hold;
  int                cycles = 0;
  int                bytes_sent = 0;
  int                payloads_sent = 0;

  dhcp_reply_option_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    forever begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) chk.check_reply(out_data_o);
  end

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic write_xid(input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    chk.xid_cfg = v;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    logic fire;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, last_byte: is_last};
    do begin
      @(negedge clk_i);
      fire = in_ready_o;
      @(posedge clk_i);
    end while (!fire);
    bytes_sent++;
    chk.take_byte('{data_byte: b, last_byte: is_last});
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
    payloads_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (chk.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_header(input logic [7:0] op, input logic [31:0] xid);
    logic [31:0] yi, si;
    yi = random_word();
    si = random_word();
    for (int i = 0; i < HeaderBytes; i++) pkt_bytes.push_back(8'($urandom));
    pkt_bytes[OFF_OPCODE] = op;
    for (int i = 0; i < 4; i++) begin
      pkt_bytes[OFF_XID_FIRST + i] = xid[31 - 8 * i -: 8];
      pkt_bytes[OFF_YI_FIRST + i]  = yi[31 - 8 * i -: 8];
      pkt_bytes[OFF_SI_FIRST + i]  = si[31 - 8 * i -: 8];
    end
  endtask

  task automatic push_opt(input logic [7:0] code, input int len, input logic [31:0] v);
    pkt_bytes.push_back(code);
    pkt_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) begin
      pkt_bytes.push_back(i < 4 ? v[31 - 8 * i -: 8] : 8'($urandom));
    end
  endtask

  task automatic truncate_to(input int len);
    while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
  endtask

  task automatic send_short_payload();
    repeat ($urandom_range(1, 5)) pkt_bytes.push_back(8'($urandom));
    send_packet();
  endtask

  task automatic run_directed();
    write_xid(32'hFFFF_FFFF);
    // single-byte payloads, both extremes
    pkt_bytes.push_back(8'hFF);
    send_packet();
    pkt_bytes.push_back(8'h00);
    send_packet();
    // duplicates, short values, pad, unknown code, end and trailing bytes
    push_header(OP_REPLY, 32'hFFFF_FFFF);
    push_opt(OPT_TYPE, 0, 32'h0);
    push_opt(OPT_TYPE, 2, 32'h0500_0000);
    push_opt(OPT_TYPE, 1, 32'h0600_0000);
    push_opt(OPT_MASK, 3, 32'hFFFF_FF00);
    push_opt(OPT_MASK, 4, 32'hFFFF_0000);
    push_opt(OPT_MASK, 4, 32'hFF00_0000);
    pkt_bytes.push_back(OPT_PAD);
    push_opt(OPT_ROUTER, 8, 32'hFFFF_FFFF);
    push_opt(OPT_SERVER_ID, 2, 32'h1234_0000);
    push_opt(OPT_SERVER_ID, 4, 32'hFFFF_FFFF);
    push_opt(OPT_DNS, 8, 32'h0A00_0001);
    push_opt(OPT_DNS, 4, 32'h0808_0808);
    push_opt(OPT_LEASE, 4, 32'hFFFF_FFFF);
    push_opt(OPT_DOMAIN, 0, 32'h0);
    push_opt(OPT_PRIVATE, 5, 32'h3500_0000);
    pkt_bytes.push_back(OPT_END);
    repeat (3) pkt_bytes.push_back(8'($urandom));
    send_packet();
    // request opcode, long dns list, then cut inside a value
    push_header(OP_REQUEST, 32'hFFFF_FFFF);
    push_opt(OPT_DNS, 12, 32'h0102_0304);
    push_opt(OPT_LEASE, 4, 32'h0001_5180);
    truncate_to(pkt_bytes.size() - 2);
    send_packet();
    wait_drained();
  endtask

  initial begin
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    logic [31:0] xid_mix[4];
    idle_mix  = '{0, 50, 0, 31};
    stall_mix = '{0, 0, 50, 31};
    xid_mix   = '{32'h0000_0000, $urandom, 32'hFFFF_FFFF, $urandom};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      write_xid(xid_mix[p]);
      for (int k = 0; k < ShortPerPhase; k++) begin
        send_short_payload();
        if ($urandom_range(3) == 0) wait_drained();
      end
      if (p == 0) begin
        // back-pressure: receiver holds off while short payloads pile up
        -> start_hold;
        repeat (HoldPayloads) begin
          pkt_bytes.push_back(8'($urandom));
          send_packet();
        end
      end
      wait_drained();
    end

    $display("sent %0d bytes in %0d payloads: directed option walks, then short payloads",
             bytes_sent, payloads_sent);
    $display("under four idling mixes and a long receiver hold; %0d ok, %0d short, %0d cut, %0d valid",
             chk.status_count[STATUS_OK], chk.status_count[STATUS_SHORT],
             chk.status_count[STATUS_CUT], chk.valid_replies);
    if (chk.mismatches == 0 && chk.expected_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", chk.mismatches,
               chk.expected_replies.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
